>>> src/cbct_pkg.sv
`timescale 1ns / 1ps

package cbct_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH  = 80;
    localparam int FRAME_HEIGHT = 60;

    localparam int COL_W   = $clog2(FRAME_WIDTH);
    localparam int ROW_W   = $clog2(FRAME_HEIGHT);
    localparam int CNT_W   = $clog2(FRAME_WIDTH * FRAME_HEIGHT + 1);
    localparam int MAX_DIM = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int SUM_W   = $clog2((MAX_DIM - 1) * FRAME_WIDTH * FRAME_HEIGHT + 1);

    // Centroid registers hold at least the output field width
    localparam int CX_W = (COL_W > 7) ? COL_W : 7;
    localparam int CY_W = (ROW_W > 6) ? ROW_W : 6;
    // Count compare width against the 13-bit minimum
    localparam int CMP_W = (CNT_W > 13) ? CNT_W : 13;

    // Shared add/sub unit width (signed two's complement)
    localparam int UNIT_W = 12;

    // Reset values
    localparam int RST_TARGET_RED   = 255;
    localparam int RST_TARGET_GREEN = 165;
    localparam int RST_TARGET_BLUE  = 0;
    localparam int RST_MARGIN       = 20;
    localparam int RST_LIMIT        = 100;
    localparam int RST_MIN_PIXELS   = 50;
    localparam int RST_HIGHLIGHT    = 16'hF800;
    localparam int RST_CENTROID     = 37;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_RED   = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_BLUE  = 3'd2,
        REG_MARGIN       = 3'd3,
        REG_LIMIT        = 3'd4,
        REG_MIN_PIXELS   = 3'd5,
        REG_HIGHLIGHT    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  target_red;
        logic [7:0]  target_green;
        logic [7:0]  target_blue;
        logic [7:0]  dominance_margin;
        logic [9:0]  distance_limit;
        logic [12:0] min_pixels;
        logic [15:0] highlight_color;
    } t_cfg;

    // Match unit status
    typedef struct packed {
        logic done;
        logic hit;
    } t_match_res;

endpackage

>>> src/cbct_match.sv
`timescale 1ns / 1ps

// Color match test, stepped through one shared add/sub unit
module cbct_match
    import cbct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [15:0]      i_pixel,
    input  t_cfg             i_cfg,
    output t_match_res       o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOM,
        S_DOMCHK,
        S_DIFF,
        S_NEG,
        S_ACC,
        S_LIM
    } t_state;

    t_state              r_state;
    logic [15:0]         r_pix;
    logic [1:0]          r_k;
    logic [UNIT_W-1:0]   r_tmp;
    logic [UNIT_W-1:0]   r_acc;
    logic                r_done;
    logic                r_hit;

    logic [7:0]          w_r;
    logic [7:0]          w_g;
    logic [7:0]          w_b;
    logic [7:0]          w_chan;
    logic [7:0]          w_targ;
    logic [UNIT_W-1:0]   w_a;
    logic [UNIT_W-1:0]   w_b_op;
    logic                w_sub;
    logic [UNIT_W-1:0]   w_sum;

    // Widen RGB565 to 8 bits per channel
    assign w_r = {r_pix[15:11], r_pix[15:13]};
    assign w_g = {r_pix[10:5], r_pix[10:9]};
    assign w_b = {r_pix[4:0], r_pix[4:2]};

    // Channel select by step index
    always_comb begin
        unique case (r_k)
            2'd0:    begin w_chan = w_r; w_targ = i_cfg.target_red;   end
            2'd1:    begin w_chan = w_g; w_targ = i_cfg.target_green; end
            default: begin w_chan = w_b; w_targ = i_cfg.target_blue;  end
        endcase
    end

    // Operand routing for the shared unit
    always_comb begin
        w_a    = '0;
        w_b_op = '0;
        w_sub  = 1'b1;
        unique case (r_state)
            S_DOM: begin
                w_a    = UNIT_W'(w_r);
                w_b_op = UNIT_W'(w_chan);
            end
            S_DOMCHK: begin
                w_a    = UNIT_W'(i_cfg.dominance_margin);
                w_b_op = r_tmp;
            end
            S_DIFF: begin
                w_a    = UNIT_W'(w_chan);
                w_b_op = UNIT_W'(w_targ);
            end
            S_NEG: begin
                w_a    = UNIT_W'(w_targ);
                w_b_op = UNIT_W'(w_chan);
            end
            S_ACC: begin
                w_a    = r_acc;
                w_b_op = r_tmp;
                w_sub  = 1'b0;
            end
            S_LIM: begin
                w_a    = r_acc;
                w_b_op = UNIT_W'(i_cfg.distance_limit);
            end
            default: begin
                w_a    = '0;
                w_b_op = '0;
            end
        endcase
    end

    // The shared adder
    assign w_sum = w_a + (w_sub ? ~w_b_op : w_b_op) + UNIT_W'(w_sub);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
            r_k     <= '0;
        end else begin
            // done pulses on an early reject or after the limit check
            r_done <= ((r_state == S_DOMCHK) && !w_sum[UNIT_W-1]) || (r_state == S_LIM);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pix   <= i_pixel;
                        r_k     <= 2'd1;
                        r_acc   <= '0;
                        r_state <= S_DOM;
                    end
                end
                S_DOM: begin
                    r_tmp   <= w_sum;
                    r_state <= S_DOMCHK;
                end
                S_DOMCHK: begin
                    // margin - (r - c) >= 0 means red does not dominate
                    if (!w_sum[UNIT_W-1]) begin
                        r_hit   <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_k == 2'd2) begin
                        r_k     <= 2'd0;
                        r_state <= S_DIFF;
                    end else begin
                        r_k     <= 2'd2;
                        r_state <= S_DOM;
                    end
                end
                S_DIFF: begin
                    r_tmp   <= w_sum;
                    r_state <= w_sum[UNIT_W-1] ? S_NEG : S_ACC;
                end
                S_NEG: begin
                    r_tmp   <= w_sum;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= w_sum;
                    if (r_k == 2'd2) begin
                        r_state <= S_LIM;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_DIFF;
                    end
                end
                S_LIM: begin
                    // distance - limit < 0
                    r_hit   <= w_sum[UNIT_W-1];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.hit  = r_hit;

    // A result is posted only on the way back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("match done outside idle");

    // Start is never issued while a test is running
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("match start while busy");

    // Channel index stays on the three channels
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != 2'd3)
        else $error("channel index out of range");

endmodule

>>> src/cbct_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module cbct_div
    import cbct_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    w_shift;
    logic [CNT_W+1:0]  w_trial;

    // Shift in next dividend bit and try a subtract
    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            // done pulses after the last quotient bit
            r_done <= r_busy && (r_iter == ITER_W'(1));
            if (!r_busy) begin
                if (i_start) begin
                    r_quo  <= i_dividend;
                    r_rem  <= '0;
                    r_div  <= i_divisor;
                    r_iter <= ITER_W'(SUM_W);
                    r_busy <= 1'b1;
                end
            end else begin
                if (!w_trial[CNT_W+1]) begin
                    r_rem <= w_trial[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
                r_iter <= r_iter - ITER_W'(1);
                if (r_iter == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // Never divide by zero
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |-> i_divisor != '0)
        else $error("divide by zero");

    // Done follows the last iteration
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without run");

endmodule

>>> src/color_blob_centroid_tracker_core.sv
`timescale 1ns / 1ps

// Color blob centroid tracker.
// Pixels (RGB565, raster order) enter on the s_axis channel, one word each;
// the block keeps its own column and row count, so the first word after
// reset is the top-left pixel of a frame. Each pixel leaves on m_axis as one
// word: tdata carries the display pixel (highlight color for a match), the
// found flag, the centroid and the frame match count; tuser flags a match and
// tlast marks the frame's last pixel.
// Per pixel the color test runs step by step on one shared add/sub unit
// after a start pulse; with a ready receiver a word is taken once the block
// is back in idle, and the next pixel is accepted in that same cycle. On the
// last pixel of a frame with enough matches a shared bit-serial divider runs
// twice, first for the mean column and then for the mean row. s_axis_tready
// is high only while the block is idle; a finished word waits in the output
// register while the next pixel is already being tested, and the block holds
// that next result until the receiver takes the first. Reset (synchronous,
// active low) restores the default registers, zeroes the position and sums
// and sets the centroid to 37,37. Registers are written on the cfg channel
// (always ready); the user must keep writes to idle, unchecked by the block.
module color_blob_centroid_tracker_core
    import cbct_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] pixel
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] out_pixel, [16] object_found, [23:17] center_x,
    // [29:24] center_y, [42:30] target_total, [47:43] zero
    output logic [47:0]          m_axis_tdata,
    output logic                 m_axis_tlast,   // frame_done
    output logic                 m_axis_tuser,   // is_target
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_MATCH,
        T_ACC,
        T_DIVC,
        T_DIVR,
        T_OUT
    } t_state;

    t_state              r_state;
    t_cfg                r_cfg;

    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_pcol;
    logic [ROW_W-1:0]    r_prow;
    logic [SUM_W-1:0]    r_sum_col;
    logic [SUM_W-1:0]    r_sum_row;
    logic [CNT_W-1:0]    r_cnt;
    logic [CX_W-1:0]     r_cent_col;
    logic [CY_W-1:0]     r_cent_row;

    logic [15:0]         r_pix;
    logic                r_last;
    logic                r_hit;
    logic                r_found;
    logic                r_m_start;
    logic                r_div_start;
    logic                r_div_sel;

    logic                r_ovalid;
    logic [47:0]         r_odata;
    logic                r_olast;
    logic                r_ouser;

    t_match_res          w_mres;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_quo;
    logic [SUM_W-1:0]    w_dividend;
    logic                w_in_acc;
    logic                w_last_pos;
    logic                w_go_div;
    logic [12:0]         w_total;
    logic [15:0]         w_opix;

    // Register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_red       <= 8'(RST_TARGET_RED);
            r_cfg.target_green     <= 8'(RST_TARGET_GREEN);
            r_cfg.target_blue      <= 8'(RST_TARGET_BLUE);
            r_cfg.dominance_margin <= 8'(RST_MARGIN);
            r_cfg.distance_limit   <= 10'(RST_LIMIT);
            r_cfg.min_pixels       <= 13'(RST_MIN_PIXELS);
            r_cfg.highlight_color  <= 16'(RST_HIGHLIGHT);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TARGET_RED:   r_cfg.target_red       <= i_cfg_data[7:0];
                REG_TARGET_GREEN: r_cfg.target_green     <= i_cfg_data[7:0];
                REG_TARGET_BLUE:  r_cfg.target_blue      <= i_cfg_data[7:0];
                REG_MARGIN:       r_cfg.dominance_margin <= i_cfg_data[7:0];
                REG_LIMIT:        r_cfg.distance_limit   <= i_cfg_data[9:0];
                REG_MIN_PIXELS:   r_cfg.min_pixels       <= i_cfg_data[12:0];
                REG_HIGHLIGHT:    r_cfg.highlight_color  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cbct_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_m_start),
        .i_pixel (r_pix),
        .i_cfg   (r_cfg),
        .o_res   (w_mres)
    );

    assign w_dividend = r_div_sel ? r_sum_row : r_sum_col;

    cbct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign s_axis_tready = (r_state == T_IDLE);
    assign w_in_acc      = s_axis_tvalid && (r_state == T_IDLE);
    assign w_last_pos    = (r_col == COL_W'(FRAME_WIDTH - 1)) &&
                           (r_row == ROW_W'(FRAME_HEIGHT - 1));
    assign w_go_div      = r_last && (CMP_W'(r_cnt) > CMP_W'(r_cfg.min_pixels));
    assign w_total       = r_found ? 13'(r_cnt) : 13'd0;
    assign w_opix        = r_hit ? r_cfg.highlight_color : r_pix;

    // Sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_sum_col   <= '0;
            r_sum_row   <= '0;
            r_cnt       <= '0;
            r_cent_col  <= CX_W'(RST_CENTROID);
            r_cent_row  <= CY_W'(RST_CENTROID);
            r_m_start   <= 1'b0;
            r_div_start <= 1'b0;
            r_div_sel   <= 1'b0;
            r_found     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            // one-cycle start pulses for the match unit and the divider
            r_m_start   <= w_in_acc;
            r_div_start <= ((r_state == T_ACC) && w_go_div) ||
                           ((r_state == T_DIVC) && w_div_done);
            if (r_ovalid && m_axis_tready && (r_state != T_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (w_in_acc) begin
                        r_pix     <= s_axis_tdata;
                        r_pcol    <= r_col;
                        r_prow    <= r_row;
                        r_last    <= w_last_pos;
                        r_state   <= T_MATCH;
                        // raster position advance
                        if (r_col >= COL_W'(FRAME_WIDTH - 1)) begin
                            r_col <= '0;
                            if (r_row >= ROW_W'(FRAME_HEIGHT - 1)) begin
                                r_row <= '0;
                            end else begin
                                r_row <= r_row + ROW_W'(1);
                            end
                        end else begin
                            r_col <= r_col + COL_W'(1);
                        end
                    end
                end
                T_MATCH: begin
                    if (w_mres.done) begin
                        r_hit <= w_mres.hit;
                        if (w_mres.hit) begin
                            r_sum_col <= r_sum_col + SUM_W'(r_pcol);
                            r_sum_row <= r_sum_row + SUM_W'(r_prow);
                            r_cnt     <= r_cnt + CNT_W'(1);
                        end
                        r_state <= T_ACC;
                    end
                end
                T_ACC: begin
                    if (w_go_div) begin
                        r_found     <= 1'b1;
                        r_div_sel   <= 1'b0;
                        r_state     <= T_DIVC;
                    end else begin
                        r_found <= 1'b0;
                        r_state <= T_OUT;
                    end
                end
                T_DIVC: begin
                    if (w_div_done) begin
                        r_cent_col  <= CX_W'(w_quo);
                        r_div_sel   <= 1'b1;
                        r_state     <= T_DIVR;
                    end
                end
                T_DIVR: begin
                    if (w_div_done) begin
                        r_cent_row <= CY_W'(w_quo);
                        r_state    <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {5'd0, w_total, 6'(r_cent_row), 7'(r_cent_col),
                                     r_found, w_opix};
                        r_olast  <= r_last;
                        r_ouser  <= r_hit;
                        if (r_last) begin
                            r_sum_col <= '0;
                            r_sum_row <= '0;
                            r_cnt     <= '0;
                        end
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ouser;

    // Object found is only reported on a frame's last word
    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[16]) |-> m_axis_tlast)
        else $error("object found outside frame end");

    // The divider only runs for a frame end with enough matches
    a_div_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_DIVC || r_state == T_DIVR) |-> (r_last && r_found))
        else $error("centroid division outside frame end");

    // No new pixel is taken until the previous one left the sequencer
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == T_MATCH)
        else $error("accept did not start a match");

endmodule

>>> sim/tb_color_blob_centroid_tracker_core.sv
`timescale 1ns / 1ps

module tb_color_blob_centroid_tracker_core;
    import cbct_pkg::*;

    // Index with no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    // RGB565 orange that hits the reset target at distance 1
    localparam logic [15:0] ORANGE_565 = 16'hFD20;

    typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} t_idle_mode;

    // One expected output word
    typedef struct {
        logic [15:0] out_pixel;
        logic        is_target;
        logic        frame_done;
        logic        object_found;
        logic [6:0]  center_x;
        logic [5:0]  center_y;
        logic [12:0] target_total;
    } t_blob_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [47:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    color_blob_centroid_tracker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Tracker state mirrored on the testbench side
    t_cfg   trk_cfg;
    int     trk_col;
    int     trk_row;
    longint trk_sum_col;
    longint trk_sum_row;
    longint trk_count;
    longint trk_cx;
    longint trk_cy;

    t_blob_word expected_words[$];
    t_blob_word want;
    int         mismatches;

    t_idle_mode tx_idle;
    t_idle_mode rx_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("tb_color_blob_centroid_tracker_core: done, errors");
        $finish;
    end

    function automatic int draw_gap(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(15) == 0) ? $urandom_range(12) : 0;
            default:     return $urandom_range(12);
        endcase
    endfunction

    function automatic int color_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    task automatic reset_tracker();
        trk_cfg.target_red       = 8'(RST_TARGET_RED);
        trk_cfg.target_green     = 8'(RST_TARGET_GREEN);
        trk_cfg.target_blue      = 8'(RST_TARGET_BLUE);
        trk_cfg.dominance_margin = 8'(RST_MARGIN);
        trk_cfg.distance_limit   = 10'(RST_LIMIT);
        trk_cfg.min_pixels       = 13'(RST_MIN_PIXELS);
        trk_cfg.highlight_color  = 16'(RST_HIGHLIGHT);
        trk_col     = 0;
        trk_row     = 0;
        trk_sum_col = 0;
        trk_sum_row = 0;
        trk_count   = 0;
        trk_cx      = RST_CENTROID;
        trk_cy      = RST_CENTROID;
    endtask

    // Color test, accumulation and end-of-frame centroid for one pixel
    function automatic t_blob_word track_pixel(input logic [15:0] pix);
        t_blob_word w;
        logic [7:0] r, g, b;
        int         gap_sum;
        int         margin;
        logic       hit;
        logic       frame_end;
        r = {pix[15:11], pix[15:13]};
        g = {pix[10:5], pix[10:9]};
        b = {pix[4:0], pix[4:2]};
        margin  = int'(trk_cfg.dominance_margin);
        gap_sum = color_gap(r, trk_cfg.target_red) + color_gap(g, trk_cfg.target_green) +
                  color_gap(b, trk_cfg.target_blue);
        hit = (int'(r) > int'(g) + margin) && (int'(r) > int'(b) + margin) &&
              (gap_sum < int'(trk_cfg.distance_limit));
        frame_end = (trk_col == FRAME_WIDTH - 1) && (trk_row == FRAME_HEIGHT - 1);
        w.object_found = 1'b0;
        w.target_total = '0;
        if (hit) begin
            trk_sum_col += trk_col;
            trk_sum_row += trk_row;
            trk_count++;
        end
        if (frame_end) begin
            if (trk_count > longint'(trk_cfg.min_pixels)) begin
                trk_cx = trk_sum_col / trk_count;
                trk_cy = trk_sum_row / trk_count;
                w.object_found = 1'b1;
                w.target_total = 13'(trk_count);
            end
            trk_sum_col = 0;
            trk_sum_row = 0;
            trk_count   = 0;
        end
        // raster position of the next pixel
        if (trk_col >= FRAME_WIDTH - 1) begin
            trk_col = 0;
            trk_row = (trk_row >= FRAME_HEIGHT - 1) ? 0 : trk_row + 1;
        end else begin
            trk_col++;
        end
        w.out_pixel  = hit ? trk_cfg.highlight_color : pix;
        w.is_target  = hit;
        w.frame_done = frame_end;
        w.center_x   = 7'(trk_cx);
        w.center_y   = 6'(trk_cy);
        return w;
    endfunction

    // Drop valid, then wait until every expected word is back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TARGET_RED:   trk_cfg.target_red       = data[7:0];
            REG_TARGET_GREEN: trk_cfg.target_green     = data[7:0];
            REG_TARGET_BLUE:  trk_cfg.target_blue      = data[7:0];
            REG_MARGIN:       trk_cfg.dominance_margin = data[7:0];
            REG_LIMIT:        trk_cfg.distance_limit   = data[9:0];
            REG_MIN_PIXELS:   trk_cfg.min_pixels       = data[12:0];
            REG_HIGHLIGHT:    trk_cfg.highlight_color  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_defaults();
        write_reg(REG_TARGET_RED, 16'(RST_TARGET_RED));
        write_reg(REG_TARGET_GREEN, 16'(RST_TARGET_GREEN));
        write_reg(REG_TARGET_BLUE, 16'(RST_TARGET_BLUE));
        write_reg(REG_MARGIN, 16'(RST_MARGIN));
        write_reg(REG_LIMIT, 16'(RST_LIMIT));
        write_reg(REG_MIN_PIXELS, 16'(RST_MIN_PIXELS));
        write_reg(REG_HIGHLIGHT, 16'(RST_HIGHLIGHT));
    endtask

    // Random settings; upper data bits are random so masking is exercised
    task automatic randomize_regs();
        write_reg(REG_TARGET_RED, 16'($urandom_range(128, 255)) | {8'($urandom), 8'h00});
        write_reg(REG_TARGET_GREEN, 16'($urandom));
        write_reg(REG_TARGET_BLUE, 16'($urandom));
        write_reg(REG_MARGIN, {8'($urandom), 8'($urandom_range(40))});
        write_reg(REG_LIMIT, {6'($urandom), 10'($urandom_range(40, 500))});
        write_reg(REG_MIN_PIXELS, 16'($urandom));
        write_reg(REG_HIGHLIGHT, 16'($urandom));
    endtask

    task automatic send_pixel(input logic [15:0] pix);
        int gap;
        gap = draw_gap(tx_idle);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = pix;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_words.push_back(track_pixel(pix));
    endtask

    function automatic logic [7:0] jitter(input logic [7:0] base);
        int v;
        v = int'(base) + int'($urandom_range(48)) - 24;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Pixel close to the current target color
    function automatic logic [15:0] near_target_pixel();
        logic [7:0] r, g, b;
        r = jitter(trk_cfg.target_red);
        g = jitter(trk_cfg.target_green);
        b = jitter(trk_cfg.target_blue);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Corner colors under the reset settings
    task automatic test_color_cases();
        logic [15:0] colors[8] = '{16'h0000, 16'hFFFF, 16'hF800, ORANGE_565,
                                   16'hFC00, 16'h07E0, 16'h001F, 16'hF81F};
        tx_idle = IDLE_FULL;
        rx_idle = IDLE_FULL;
        foreach (colors[i]) send_pixel(colors[i]);
    endtask

    // Red lead over green exactly at the margin, one below, and margin at max and at zero
    task automatic test_dominance_edge();
        write_reg(REG_MARGIN, 16'd89);
        send_pixel(ORANGE_565);
        write_reg(REG_MARGIN, 16'd88);
        send_pixel(ORANGE_565);
        write_reg(REG_MARGIN, 16'd255);
        send_pixel(16'hF800);
        write_reg(REG_MARGIN, 16'd0);
        send_pixel(16'h8410);
        write_reg(REG_MARGIN, 16'(RST_MARGIN));
    endtask

    // Distance exactly at the limit, a zero limit, and limit bits above range
    task automatic test_distance_edge();
        write_reg(REG_LIMIT, 16'd1);
        send_pixel(ORANGE_565);
        write_reg(REG_LIMIT, 16'd2);
        send_pixel(ORANGE_565);
        write_reg(REG_TARGET_GREEN, 16'd166);
        write_reg(REG_LIMIT, 16'hFC00);
        send_pixel(ORANGE_565);
        write_reg(REG_LIMIT, 16'hFFFF);
        send_pixel(16'hF800);
    endtask

    // Highlight extremes, far target, and a write to the unused index
    task automatic test_register_extremes();
        write_reg(REG_HIGHLIGHT, 16'h0000);
        send_pixel(ORANGE_565);
        write_reg(REG_HIGHLIGHT, 16'hFFFF);
        send_pixel(ORANGE_565);
        write_reg(REG_TARGET_RED, 16'h0000);
        write_reg(REG_TARGET_BLUE, 16'hFFFF);
        send_pixel(ORANGE_565);
        write_reg(REG_SPARE, 16'hFFFF);
        send_pixel(ORANGE_565);
        load_defaults();
    endtask

    // Random pixels over several random settings
    task automatic test_random_pixels();
        t_idle_mode modes[3] = '{IDLE_NONE, IDLE_SPARSE, IDLE_FULL};
        for (int set = 0; set < 3; set++) begin
            randomize_regs();
            for (int n = 0; n < 250; n++) begin
                if (n % 50 == 0) begin
                    tx_idle = modes[$urandom_range(2)];
                    rx_idle = modes[$urandom_range(2)];
                end
                send_pixel($urandom_range(1) ? near_target_pixel() : 16'($urandom));
            end
        end
    endtask

    // Receiver: stall drawn per word
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap(rx_idle);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got);
        if (got !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got);
            mismatches++;
        end
    endtask

    // Compare each output word with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("output word with nothing expected: tdata 0x%0h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("out_pixel", want.out_pixel, m_axis_tdata[15:0]);
                check_field("object_found", want.object_found, m_axis_tdata[16]);
                check_field("center_x", want.center_x, m_axis_tdata[23:17]);
                check_field("center_y", want.center_y, m_axis_tdata[29:24]);
                check_field("target_total", want.target_total, m_axis_tdata[42:30]);
                check_field("tdata_pad", 0, m_axis_tdata[47:43]);
                check_field("frame_done", want.frame_done, m_axis_tlast);
                check_field("is_target", want.is_target, m_axis_tuser);
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_TARGET_RED;
        i_cfg_data    = '0;
        mismatches    = 0;
        tx_idle       = IDLE_NONE;
        rx_idle       = IDLE_NONE;
        reset_tracker();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_color_cases();
        test_dominance_edge();
        test_distance_edge();
        test_register_extremes();
        test_random_pixels();

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_color_blob_centroid_tracker_core: done, clean");
        else
            $display("tb_color_blob_centroid_tracker_core: done, errors");
        $finish;
    end

endmodule

>>> files.f
src/cbct_pkg.sv
src/cbct_match.sv
src/cbct_div.sv
src/color_blob_centroid_tracker_core.sv
sim/tb_color_blob_centroid_tracker_core.sv
